### rtl/core/quad_axis_pid_attitude_macros.svh
// Assertion macros shared by the attitude controller RTL.
`ifndef QUAD_AXIS_PID_ATTITUDE_MACROS_SVH
`define QUAD_AXIS_PID_ATTITUDE_MACROS_SVH

// Same-cycle implication under the block's clock and reset.
`define QAPA_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication under the block's clock and reset.
`define QAPA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/qapa_pkg.sv
// Package: beat types, register indexes and the CORDIC arctangent table.
package qapa_pkg;

   typedef struct packed {
      logic signed [23:0] altitude;
      logic signed [15:0] pitch_angle;
      logic signed [15:0] roll_angle;
      logic signed [15:0] heading_angle;
   } req_beat_type;

   typedef struct packed {
      logic signed [31:0] height_drive;
      logic signed [31:0] roll_drive;
      logic signed [31:0] pitch_drive;
      logic signed [31:0] yaw_drive;
   } rsp_beat_type;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 48;

   localparam logic [CSR_INDEX_W-1:0] REG_GOAL_HEIGHT  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_GOAL_SIDE    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_GOAL_FORWARD = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_GOAL_HEADING = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_HEIGHT_GAINS = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_ROLL_GAINS   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_PITCH_GAINS  = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_YAW_GAINS    = 3'd7;

   localparam longint PI_Q30      = 64'd3373259426;
   localparam longint HALF_PI_Q30 = 64'd1686629713;
   localparam int     ATAN_STEPS  = 24;

   // atan(2^-i) in Q30 radians
   function automatic logic [30:0] atan_q30(input logic [4:0] idx);
      logic [30:0] v;
      case (idx)
         5'd0: v = 31'd843314857;
         5'd1: v = 31'd497837830;
         5'd2: v = 31'd263043837;
         5'd3: v = 31'd133525159;
         5'd4: v = 31'd67021687;
         5'd5: v = 31'd33543516;
         5'd6: v = 31'd16775851;
         5'd7: v = 31'd8388437;
         5'd8: v = 31'd4194283;
         5'd9: v = 31'd2097149;
         5'd10: v = 31'd1048576;
         5'd11: v = 31'd524288;
         5'd12: v = 31'd262144;
         5'd13: v = 31'd131072;
         5'd14: v = 31'd65536;
         5'd15: v = 31'd32768;
         5'd16: v = 31'd16384;
         5'd17: v = 31'd8192;
         5'd18: v = 31'd4096;
         5'd19: v = 31'd2048;
         5'd20: v = 31'd1024;
         5'd21: v = 31'd512;
         5'd22: v = 31'd256;
         5'd23: v = 31'd128;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

### rtl/core/quad_axis_pid_attitude.sv
// Four-axis PID attitude controller with CORDIC bearings and angle wrap.
//
//   port group | dir | beat / content
//   req_*      | in  | navigation sample: altitude, pitch, roll, heading
//   rsp_*      | out | drive beat: height, roll, pitch, yaw drives
//   csr_*      | in  | register write: index, 48-bit data, no read-back
//
// One sample at a time: a new sample is taken only after the drive beat
//   has left. Each loop uses the shared 16x26 multiplier (three products
//   per loop, each in two halves, multiply then accumulate); the roll and
//   pitch loops first run the CORDIC iterations. Wrap removes 2*pi
//   repeatedly until the angle lies in (-pi, pi].
// Reset clears integrators, previous errors, configuration registers and the sequencer.
// req_stall is high from accept until the drive beat leaves; a stalled
// drive beat stays registered and unchanged.
module quad_axis_pid_attitude
   import qapa_pkg::*;
#(
   parameter int GAIN_FRAC_BITS  = 8,
   parameter int ANGLE_FRAC_BITS = 13,
   parameter int CORDIC_STEPS    = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_beat_type           req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_beat_type           rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

`include "quad_axis_pid_attitude_macros.svh"

   localparam int NSTEP = (CORDIC_STEPS < ATAN_STEPS) ? CORDIC_STEPS : ATAN_STEPS;
   localparam int ZSH   = 30 - ANGLE_FRAC_BITS;
   localparam longint PI_Q = (PI_Q30 + (64'd1 << (ZSH - 1))) >>> ZSH;
   localparam logic signed [18:0] P_W  = 19'(PI_Q);
   localparam logic signed [18:0] TP_W = 19'(2 * PI_Q);
   localparam logic signed [33:0] Z_RND = 34'(64'd1 << (ZSH - 1));
   localparam logic signed [33:0] Z_HALF = 34'(HALF_PI_Q30);
   localparam logic signed [67:0] ACC_RND =
      (GAIN_FRAC_BITS == 0) ? 68'sd0 : 68'(64'd1 << (GAIN_FRAC_BITS - 1));
   localparam logic [4:0] LAST_STEP = 5'(NSTEP - 1);

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b0000000001,
      ST_ERR   = 10'b0000000010,
      ST_CORD  = 10'b0000000100,
      ST_ROUND = 10'b0000001000,
      ST_WRAP  = 10'b0000010000,
      ST_MUL   = 10'b0000100000,
      ST_ACC   = 10'b0001000000,
      ST_FIN   = 10'b0010000000,
      ST_OUT   = 10'b0100000000,
      ST_SPARE = 10'b1000000000
   } state_type;

   // configuration
   logic signed [23:0] goal_height_ff, goal_side_ff, goal_forward_ff;
   logic signed [15:0] goal_heading_ff;
   logic [47:0]        gains_ff [4];

   // sequencer and datapath
   state_type          state_ff, state_in;
   logic [1:0]         ax_ff, ax_in;
   logic [1:0]         term_ff, term_in;
   logic               half_ff, half_in;
   logic [4:0]         step_ff, step_in;
   req_beat_type       smp_ff, smp_in;
   logic signed [24:0] eh_ff, eh_in;
   logic signed [28:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [33:0] cz_ff, cz_in;
   logic signed [18:0] wr_ff, wr_in;
   logic signed [25:0] err_ff, err_in;
   logic signed [41:0] prod_ff, prod_in;
   logic signed [67:0] acc_ff, acc_in;
   logic signed [47:0] sum_ff [4];
   logic signed [25:0] prev_ff [4];
   logic signed [31:0] drive_ff [4];

   // combinational helpers
   logic signed [24:0] cin_x, cin_y;
   logic signed [15:0] meas_angle;
   logic signed [28:0] dx, dy;
   logic signed [33:0] z_round;
   logic signed [17:0] bearing;
   logic signed [48:0] sum_e;
   logic signed [26:0] diff_e;
   logic signed [49:0] opnd;
   logic signed [25:0] mul_b;
   logic signed [15:0] gain;
   logic signed [67:0] acc_r;
   logic signed [67:0] drv_full;
   logic signed [31:0] drv_sat;
   logic signed [47:0] sum_sat;
   logic               req_acc, rsp_acc;

   assign req_acc   = req_valid && !req_stall;
   assign rsp_acc   = rsp_valid && !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);

   assign rsp_data.height_drive = drive_ff[0];
   assign rsp_data.roll_drive   = drive_ff[1];
   assign rsp_data.pitch_drive  = drive_ff[2];
   assign rsp_data.yaw_drive    = drive_ff[3];

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         goal_height_ff  <= '0;
         goal_side_ff    <= '0;
         goal_forward_ff <= '0;
         goal_heading_ff <= '0;
         for (int i = 0; i < 4; i++) gains_ff[i] <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_GOAL_HEIGHT:  goal_height_ff  <= csr_wdata[23:0];
            REG_GOAL_SIDE:    goal_side_ff    <= csr_wdata[23:0];
            REG_GOAL_FORWARD: goal_forward_ff <= csr_wdata[23:0];
            REG_GOAL_HEADING: goal_heading_ff <= csr_wdata[15:0];
            REG_HEIGHT_GAINS: gains_ff[0]     <= csr_wdata;
            REG_ROLL_GAINS:   gains_ff[1]     <= csr_wdata;
            REG_PITCH_GAINS:  gains_ff[2]     <= csr_wdata;
            REG_YAW_GAINS:    gains_ff[3]     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // CORDIC operands: roll bearing is atan2(side, eh), pitch is atan2(eh, forward)
   always_comb begin
      if (ax_ff == 2'd1) begin
         cin_y      = 25'(goal_side_ff);
         cin_x      = eh_ff;
         meas_angle = smp_ff.roll_angle;
      end else begin
         cin_y      = eh_ff;
         cin_x      = 25'(goal_forward_ff);
         meas_angle = smp_ff.pitch_angle;
      end
   end

   assign dx      = cy_ff >>> step_ff;
   assign dy      = cx_ff >>> step_ff;
   assign z_round = cz_ff + Z_RND;
   assign bearing = 18'(z_round >>> ZSH);

   // PID operand for the current term; split into two multiplier halves
   assign sum_e  = 49'(sum_ff[ax_ff]) + 49'(err_ff);
   assign diff_e = 27'(err_ff) - 27'(prev_ff[ax_ff]);

   always_comb begin
      case (term_ff)
         2'd0:    opnd = 50'(err_ff);
         2'd1:    opnd = 50'(sum_e);
         default: opnd = 50'(diff_e);
      endcase
      case (term_ff)
         2'd0:    gain = gains_ff[ax_ff][15:0];
         2'd1:    gain = gains_ff[ax_ff][31:16];
         default: gain = gains_ff[ax_ff][47:32];
      endcase
      // upper half carries the sign, lower half is a plain magnitude
      mul_b = half_ff ? 26'($signed(opnd[49:25])) : $signed({1'b0, opnd[24:0]});
   end

   assign prod_in  = gain * mul_b;
   assign acc_r    = acc_ff + ACC_RND;
   assign drv_full = acc_r >>> GAIN_FRAC_BITS;

   always_comb begin
      if (drv_full > 68'sd2147483647)       drv_sat = 32'sh7FFFFFFF;
      else if (drv_full < -68'sd2147483648) drv_sat = 32'sh80000000;
      else                                  drv_sat = drv_full[31:0];
      if (ax_ff == 2'd0) begin
         if (sum_e[48] != sum_e[47]) sum_sat = sum_e[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
         else                        sum_sat = sum_e[47:0];
      end else begin
         if (sum_e > 49'sd2147483647)       sum_sat = 48'sh7FFFFFFF;
         else if (sum_e < -49'sd2147483648) sum_sat = -48'sd2147483648;
         else                               sum_sat = sum_e[47:0];
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      ax_in    = ax_ff;
      term_in  = term_ff;
      half_in  = half_ff;
      step_in  = step_ff;
      smp_in   = smp_ff;
      eh_in    = eh_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      cz_in    = cz_ff;
      wr_in    = wr_ff;
      err_in   = err_ff;
      acc_in   = acc_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               smp_in   = req_data;
               eh_in    = 25'(goal_height_ff) - 25'(req_data.altitude);
               ax_in    = 2'd0;
               state_in = ST_ERR;
            end
         end
         ST_ERR: begin
            term_in = 2'd0;
            half_in = 1'b0;
            acc_in  = '0;
            step_in = '0;
            case (ax_ff)
               2'd0: begin
                  err_in   = 26'(eh_ff);
                  state_in = ST_MUL;
               end
               2'd3: begin
                  wr_in    = 19'(goal_heading_ff) - 19'(smp_ff.heading_angle);
                  state_in = ST_WRAP;
               end
               default: begin
                  if (cin_x == '0 && cin_y == '0) begin
                     // zero vector: bearing is zero
                     wr_in    = -19'(meas_angle);
                     state_in = ST_WRAP;
                  end else begin
                     if (cin_x < 0) begin
                        if (cin_y >= 0) begin
                           cx_in = 29'(cin_y);
                           cy_in = -29'(cin_x);
                           cz_in = Z_HALF;
                        end else begin
                           cx_in = -29'(cin_y);
                           cy_in = 29'(cin_x);
                           cz_in = -Z_HALF;
                        end
                     end else begin
                        cx_in = 29'(cin_x);
                        cy_in = 29'(cin_y);
                        cz_in = '0;
                     end
                     state_in = ST_CORD;
                  end
               end
            endcase
         end
         ST_CORD: begin
            if (cy_ff > 0) begin
               cx_in = cx_ff + dx;
               cy_in = cy_ff - dy;
               cz_in = cz_ff + $signed(34'(atan_q30(step_ff)));
            end else begin
               cx_in = cx_ff - dx;
               cy_in = cy_ff + dy;
               cz_in = cz_ff - $signed(34'(atan_q30(step_ff)));
            end
            step_in = step_ff + 5'd1;
            if (step_ff == LAST_STEP) state_in = ST_ROUND;
         end
         ST_ROUND: begin
            wr_in    = 19'(bearing) - 19'(meas_angle);
            state_in = ST_WRAP;
         end
         ST_WRAP: begin
            // one 2*pi correction per cycle until inside (-pi, pi]
            if (wr_ff > P_W)        wr_in = wr_ff - TP_W;
            else if (wr_ff <= -P_W) wr_in = wr_ff + TP_W;
            else begin
               err_in   = 26'(wr_ff);
               state_in = ST_MUL;
            end
         end
         ST_MUL: state_in = ST_ACC;
         ST_ACC: begin
            acc_in = half_ff ? acc_ff + (68'(prod_ff) <<< 25) : acc_ff + 68'(prod_ff);
            if (half_ff) begin
               half_in = 1'b0;
               if (term_ff == 2'd2) state_in = ST_FIN;
               else begin
                  term_in  = term_ff + 2'd1;
                  state_in = ST_MUL;
               end
            end else begin
               half_in  = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_FIN: begin
            if (ax_ff == 2'd3) state_in = ST_OUT;
            else begin
               ax_in    = ax_ff + 2'd1;
               state_in = ST_ERR;
            end
         end
         ST_OUT: begin
            if (rsp_acc) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ax_ff    <= '0;
         term_ff  <= '0;
         half_ff  <= 1'b0;
         step_ff  <= '0;
         for (int i = 0; i < 4; i++) begin
            sum_ff[i]  <= '0;
            prev_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         ax_ff    <= ax_in;
         term_ff  <= term_in;
         half_ff  <= half_in;
         step_ff  <= step_in;
         if (state_ff == ST_FIN) begin
            sum_ff[ax_ff]  <= sum_sat;
            prev_ff[ax_ff] <= err_ff;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      smp_ff  <= smp_in;
      eh_ff   <= eh_in;
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      cz_ff   <= cz_in;
      wr_ff   <= wr_in;
      err_ff  <= err_in;
      acc_ff  <= acc_in;
      if (state_ff == ST_MUL) prod_ff <= prod_in;
      if (state_ff == ST_FIN) drive_ff[ax_ff] <= drv_sat;
   end

   `QAPA_ASSERT_NEXT(a_accept_starts, req_acc, state_ff == ST_ERR && ax_ff == 2'd0, "accept did not start height loop")
   `QAPA_ASSERT_NEXT(a_last_loop_out, state_ff == ST_FIN && ax_ff == 2'd3, rsp_valid, "no drive beat after yaw loop")
   `QAPA_ASSERT_NOW(a_cordic_bound, state_ff == ST_CORD, step_ff <= LAST_STEP, "CORDIC step overran")
   `QAPA_ASSERT_NEXT(a_rsp_frees, rsp_acc, !rsp_valid && !req_stall, "block not free after drive beat")

endmodule
